// ----- design/prescaled_match_timer_top_defines.svh -----
// Assertion macros used by the prescaled match timer core.
`ifndef PRESCALED_MATCH_TIMER_TOP_DEFINES_SVH
`define PRESCALED_MATCH_TIMER_TOP_DEFINES_SVH

// Checks that whenever the antecedent holds, the consequent holds in the same cycle.
`define PMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that whenever the antecedent holds, the consequent holds in the next cycle.
`define PMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pmt_pkg.sv -----
// Package with the shared types and codes of the prescaled match timer.
package pmt_pkg;

   // Fixed widths of the bus fields.
   localparam int DATA_WIDTH = 32;
   localparam int FUNC_WIDTH = 2;
   localparam int SEL_WIDTH = 3;

   // Default width of the counters, prescale value and match value.
   localparam int COUNTER_WIDTH_DEFAULT = 32;

   // Kinds of input word.
   localparam logic [FUNC_WIDTH-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_READ = 2'd2;

   // Register selects.
   localparam logic [SEL_WIDTH-1:0] REG_CONTROL = 3'd0;
   localparam logic [SEL_WIDTH-1:0] REG_MATCH_CONTROL = 3'd1;
   localparam logic [SEL_WIDTH-1:0] REG_PRESCALE = 3'd2;
   localparam logic [SEL_WIDTH-1:0] REG_MATCH_VALUE = 3'd3;
   localparam logic [SEL_WIDTH-1:0] REG_FLAGS = 3'd4;
   localparam logic [SEL_WIDTH-1:0] REG_COUNTER = 3'd5;
   localparam logic [SEL_WIDTH-1:0] REG_PRESCALE_COUNT = 3'd6;

   // One input word as held in the input register.
   typedef struct packed {
      logic [SEL_WIDTH-1:0] reg_select;
      logic [FUNC_WIDTH-1:0] func;
      logic [DATA_WIDTH-1:0] write_data;
   } item_type;

   // One result word.
   typedef struct packed {
      logic irq;
      logic [DATA_WIDTH-1:0] read_data;
   } result_type;

endpackage

// ----- design/pmt_core.sv -----
// Timer registers, tick and bus access logic of the prescaled match timer.
`include "prescaled_match_timer_top_defines.svh"

module pmt_core #(
   parameter int COUNTER_WIDTH = pmt_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   input  pmt_pkg::item_type   item,
   output pmt_pkg::result_type result
);

   logic                     count_enable_ff, count_enable_in;
   logic                     count_hold_reset_ff, count_hold_reset_in;
   logic                     match_irq_enable_ff, match_irq_enable_in;
   logic                     match_reset_enable_ff, match_reset_enable_in;
   logic [COUNTER_WIDTH-1:0] prescale_value_ff, prescale_value_in;
   logic [COUNTER_WIDTH-1:0] match_value_ff, match_value_in;
   logic                     irq_flag_ff, irq_flag_in;
   logic [COUNTER_WIDTH-1:0] timer_count_ff, timer_count_in;
   logic [COUNTER_WIDTH-1:0] prescale_count_ff, prescale_count_in;

   logic [COUNTER_WIDTH-1:0] write_value;
   logic [COUNTER_WIDTH-1:0] timer_wrap;
   logic                     prescale_wrap;

   assign write_value = item.write_data[COUNTER_WIDTH-1:0];
   assign prescale_wrap = (prescale_count_ff >= prescale_value_ff);

   // Timer count at a prescale wrap: back to zero on a match with match reset on.
   assign timer_wrap = (timer_count_ff == match_value_ff && match_reset_enable_ff)
                     ? '0 : timer_count_ff + 1'b1;

   // Next state for the word in the input register.
   always_comb begin
      count_enable_in = count_enable_ff;
      count_hold_reset_in = count_hold_reset_ff;
      match_irq_enable_in = match_irq_enable_ff;
      match_reset_enable_in = match_reset_enable_ff;
      prescale_value_in = prescale_value_ff;
      match_value_in = match_value_ff;
      irq_flag_in = irq_flag_ff;
      timer_count_in = timer_count_ff;
      prescale_count_in = prescale_count_ff;
      if (step_valid) begin
         case (item.func)
            pmt_pkg::FUNC_TICK: begin
               if (count_hold_reset_ff) begin
                  timer_count_in = '0;
                  prescale_count_in = '0;
               end else if (count_enable_ff) begin
                  if (prescale_wrap) begin
                     prescale_count_in = '0;
                     timer_count_in = timer_wrap;
                     if (timer_wrap == match_value_ff && match_irq_enable_ff) begin
                        irq_flag_in = 1'b1;
                     end
                  end else begin
                     prescale_count_in = prescale_count_ff + 1'b1;
                  end
               end
            end
            pmt_pkg::FUNC_WRITE: begin
               case (item.reg_select)
                  pmt_pkg::REG_CONTROL: begin
                     count_enable_in = item.write_data[0];
                     count_hold_reset_in = item.write_data[1];
                     if (item.write_data[1]) begin
                        timer_count_in = '0;
                        prescale_count_in = '0;
                     end
                  end
                  pmt_pkg::REG_MATCH_CONTROL: begin
                     match_irq_enable_in = item.write_data[0];
                     match_reset_enable_in = item.write_data[1];
                  end
                  pmt_pkg::REG_PRESCALE: begin
                     prescale_value_in = write_value;
                  end
                  pmt_pkg::REG_MATCH_VALUE: begin
                     match_value_in = write_value;
                  end
                  pmt_pkg::REG_FLAGS: begin
                     if (item.write_data[0]) begin
                        irq_flag_in = 1'b0;
                     end
                  end
                  pmt_pkg::REG_COUNTER: begin
                     if (!count_hold_reset_ff) begin
                        timer_count_in = write_value;
                     end
                  end
                  pmt_pkg::REG_PRESCALE_COUNT: begin
                     if (!count_hold_reset_ff) begin
                        prescale_count_in = write_value;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Read multiplexer and the flag after this word.
   always_comb begin
      result.read_data = '0;
      result.irq = irq_flag_in;
      if (item.func == pmt_pkg::FUNC_READ) begin
         case (item.reg_select)
            pmt_pkg::REG_CONTROL: begin
               result.read_data = {30'd0, count_hold_reset_ff, count_enable_ff};
            end
            pmt_pkg::REG_MATCH_CONTROL: begin
               result.read_data = {30'd0, match_reset_enable_ff, match_irq_enable_ff};
            end
            pmt_pkg::REG_PRESCALE: begin
               result.read_data = pmt_pkg::DATA_WIDTH'(prescale_value_ff);
            end
            pmt_pkg::REG_MATCH_VALUE: begin
               result.read_data = pmt_pkg::DATA_WIDTH'(match_value_ff);
            end
            pmt_pkg::REG_FLAGS: begin
               result.read_data = {31'd0, irq_flag_ff};
            end
            pmt_pkg::REG_COUNTER: begin
               result.read_data = pmt_pkg::DATA_WIDTH'(timer_count_ff);
            end
            pmt_pkg::REG_PRESCALE_COUNT: begin
               result.read_data = pmt_pkg::DATA_WIDTH'(prescale_count_ff);
            end
            default: begin
               result.read_data = '0;
            end
         endcase
      end
   end

   // All timer registers, the control bits and the flag are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_enable_ff <= 1'b0;
         count_hold_reset_ff <= 1'b0;
         match_irq_enable_ff <= 1'b0;
         match_reset_enable_ff <= 1'b0;
         prescale_value_ff <= '0;
         match_value_ff <= '0;
         irq_flag_ff <= 1'b0;
         timer_count_ff <= '0;
         prescale_count_ff <= '0;
      end else begin
         count_enable_ff <= count_enable_in;
         count_hold_reset_ff <= count_hold_reset_in;
         match_irq_enable_ff <= match_irq_enable_in;
         match_reset_enable_ff <= match_reset_enable_in;
         prescale_value_ff <= prescale_value_in;
         match_value_ff <= match_value_in;
         irq_flag_ff <= irq_flag_in;
         timer_count_ff <= timer_count_in;
         prescale_count_ff <= prescale_count_in;
      end
   end

   // While held in counter reset both counters sit at zero.
   `PMT_ASSERT_SAME(a_hold_clears_counters, clock, reset, count_hold_reset_ff,
      (timer_count_ff == '0 && prescale_count_ff == '0), "counter not zero during hold")

   // The flag is only set by a tick with match interrupts enabled.
   `PMT_ASSERT_SAME(a_flag_set_by_tick, clock, reset, $rose(irq_flag_ff),
      ($past(step_valid) && $past(item.func) == pmt_pkg::FUNC_TICK
       && $past(match_irq_enable_ff)), "flag set without an enabled match")

   // The flag only clears through a write to the flags register or through reset.
   `PMT_ASSERT_SAME(a_flag_clear_by_write, clock, reset, $fell(irq_flag_ff),
      ($past(reset) || ($past(step_valid) && $past(item.func) == pmt_pkg::FUNC_WRITE
       && $past(item.reg_select) == pmt_pkg::REG_FLAGS)), "flag cleared unexpectedly")

endmodule

// ----- design/prescaled_match_timer_top.sv -----
// A word taken passes through the input register, then the result register, before it is offered as a result.
// Throughput: one word per cycle in and out, with no gap while rsp_tready is high.
// The input register and result register each hold one word; while a result waits,
// req_tready stays high only until the input register is filled as well.
// Synchronous reset clears all timer registers, the flag and both valid bits.
// Top level of the prescaled match timer: input register, core and result register.
module prescaled_match_timer_top #(
   parameter int COUNTER_WIDTH = pmt_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] write_data
   input  logic [4:0]  req_tuser,  // [1:0] func, [4:2] reg_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // [31:0] read_data, [32] irq, [39:33] zero
);

   logic                in_valid_ff, in_valid_in;
   pmt_pkg::item_type   in_item_ff, in_item_in;
   logic                out_valid_ff, out_valid_in;
   pmt_pkg::result_type out_result_ff, out_result_in;
   pmt_pkg::result_type core_result;
   logic                step;

   // The word in the input register moves on when the result register is free.
   assign step = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_item_in.write_data = req_tdata;
         in_item_in.func = req_tuser[1:0];
         in_item_in.reg_select = req_tuser[4:2];
      end
   end

   pmt_core #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step_valid(step),
      .item(in_item_ff),
      .result(core_result)
   );

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_result_in = out_result_ff;
      if (!out_valid_ff || rsp_tready) begin
         out_valid_in = step;
         out_result_in = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'd0, out_result_ff.irq, out_result_ff.read_data};

endmodule

// ----- verif/prescaled_match_timer_top_tb.sv -----
// Self-checking testbench for the prescaled match timer top level.
`timescale 1ns / 1ps

module prescaled_match_timer_top_tb;

   // Codes that the package leaves unnamed but the bus can still carry.
   localparam logic [pmt_pkg::FUNC_WIDTH-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [pmt_pkg::SEL_WIDTH-1:0] REG_UNUSED = 3'd7;

   localparam int CNT_W = pmt_pkg::COUNTER_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 332;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 10;
   localparam int TX_IDLE_PCT [4] = '{0, 70, 0, 26};
   localparam int RX_STALL_PCT [4] = '{0, 0, 70, 26};

   // One expected result word.
   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
   } timer_result_type;

   // One row of the directed table; a known row carries its result typed in.
   typedef struct packed {
      logic [pmt_pkg::FUNC_WIDTH-1:0] func;
      logic [pmt_pkg::SEL_WIDTH-1:0]  sel;
      logic [31:0]                    data;
      logic                           known;
      logic [31:0]                    want_read;
      logic                           want_irq;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 27;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Reset values, the unused function and the unused select.
      '{pmt_pkg::FUNC_READ,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{FUNC_UNUSED,         REG_UNUSED,           32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{pmt_pkg::FUNC_READ,  REG_UNUSED,           32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      // Widest prescale value reads back whole.
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_PRESCALE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{pmt_pkg::FUNC_READ,  pmt_pkg::REG_PRESCALE, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
      // Count to a match with interrupt and match reset on.
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_PRESCALE, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_MATCH_VALUE, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_MATCH_CONTROL, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_CONTROL, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_TICK,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_TICK,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_TICK,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_TICK,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_READ,  pmt_pkg::REG_FLAGS, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      // A write of zero to bit 0 leaves the flag, a write of one clears it.
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_FLAGS, 32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_FLAGS, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
      // Counter overflow.
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_MATCH_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_COUNTER, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_TICK,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      // Prescale count above the prescale value wraps at once.
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_PRESCALE, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_PRESCALE_COUNT, 32'h0000_000A, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_TICK,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      // Counter reset clears both counters and discards counter writes.
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_CONTROL, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_COUNTER, 32'h0000_0005, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_READ,  pmt_pkg::REG_COUNTER, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      // Unused control bits are ignored and read as zero.
      '{pmt_pkg::FUNC_WRITE, pmt_pkg::REG_CONTROL, 32'hFFFF_FFFC, 1'b0, 32'h0, 1'b0},
      '{pmt_pkg::FUNC_READ,  pmt_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 32'h0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] write_data
   logic [4:0]  req_tuser = '0;   // [1:0] func, [4:2] reg_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] read_data, [32] irq, [39:33] zero

   prescaled_match_timer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted timer state.
   logic             enable_bit;
   logic             hold_reset_bit;
   logic             match_irq_bit;
   logic             match_reset_bit;
   logic [CNT_W-1:0] prescale_val;
   logic [CNT_W-1:0] match_val;
   logic             irq_pending;
   logic [CNT_W-1:0] timer_cnt;
   logic [CNT_W-1:0] prescale_cnt;

   timer_result_type pending_results [$];
   timer_result_type oldest;
   int unsigned   mismatch_count = 0;
   int unsigned   words_sent = 0;
   int unsigned   words_checked = 0;
   int unsigned   irq_words = 0;
   int unsigned   cycle_count = 0;
   int            tx_idle_pct = 0;
   int            rx_stall_pct = 0;
   int            hold_requests = 0;
   int            hold_served = 0;
   int            hold_left = 0;

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the result word of one accepted input word and advances the state.
   task automatic predict_timer_word(input logic [pmt_pkg::FUNC_WIDTH-1:0] func,
                                     input logic [pmt_pkg::SEL_WIDTH-1:0] sel,
                                     input logic [31:0] data,
                                     output timer_result_type res);
      res.read_data = '0;
      case (func)
         pmt_pkg::FUNC_TICK: begin
            if (hold_reset_bit) begin
               timer_cnt = '0;
               prescale_cnt = '0;
            end else if (enable_bit) begin
               if (prescale_cnt >= prescale_val) begin
                  prescale_cnt = '0;
                  if (timer_cnt == match_val && match_reset_bit)
                     timer_cnt = '0;
                  else
                     timer_cnt = timer_cnt + 1'b1;
                  if (timer_cnt == match_val && match_irq_bit)
                     irq_pending = 1'b1;
               end else begin
                  prescale_cnt = prescale_cnt + 1'b1;
               end
            end
         end
         pmt_pkg::FUNC_WRITE: begin
            case (sel)
               pmt_pkg::REG_CONTROL: begin
                  enable_bit = data[0];
                  hold_reset_bit = data[1];
                  if (data[1]) begin
                     timer_cnt = '0;
                     prescale_cnt = '0;
                  end
               end
               pmt_pkg::REG_MATCH_CONTROL: begin
                  match_irq_bit = data[0];
                  match_reset_bit = data[1];
               end
               pmt_pkg::REG_PRESCALE: prescale_val = data[CNT_W-1:0];
               pmt_pkg::REG_MATCH_VALUE: match_val = data[CNT_W-1:0];
               pmt_pkg::REG_FLAGS: if (data[0]) irq_pending = 1'b0;
               pmt_pkg::REG_COUNTER: if (!hold_reset_bit) timer_cnt = data[CNT_W-1:0];
               pmt_pkg::REG_PRESCALE_COUNT:
                  if (!hold_reset_bit) prescale_cnt = data[CNT_W-1:0];
               default: ;
            endcase
         end
         pmt_pkg::FUNC_READ: begin
            case (sel)
               pmt_pkg::REG_CONTROL: res.read_data = {30'd0, hold_reset_bit, enable_bit};
               pmt_pkg::REG_MATCH_CONTROL:
                  res.read_data = {30'd0, match_reset_bit, match_irq_bit};
               pmt_pkg::REG_PRESCALE: res.read_data = prescale_val;
               pmt_pkg::REG_MATCH_VALUE: res.read_data = match_val;
               pmt_pkg::REG_FLAGS: res.read_data = {31'd0, irq_pending};
               pmt_pkg::REG_COUNTER: res.read_data = timer_cnt;
               pmt_pkg::REG_PRESCALE_COUNT: res.read_data = prescale_cnt;
               default: ;
            endcase
         end
         default: ;
      endcase
      res.irq = irq_pending;
   endtask

   // Offers one word, waits for it to be taken and records what it should give back.
   task automatic send_word(input logic [pmt_pkg::FUNC_WIDTH-1:0] func,
                            input logic [pmt_pkg::SEL_WIDTH-1:0] sel,
                            input logic [31:0] data,
                            input logic known,
                            input timer_result_type known_res);
      timer_result_type res;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {sel, func};
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_timer_word(func, sel, data, res);
      pending_results.push_back(known ? known_res : res);
      words_sent++;
   endtask

   // Chooses a random word; values lean towards small counts so matches occur often.
   task automatic pick_random_word(output logic [pmt_pkg::FUNC_WIDTH-1:0] func,
                                   output logic [pmt_pkg::SEL_WIDTH-1:0] sel,
                                   output logic [31:0] data);
      int roll;
      int pick;
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      sel = pmt_pkg::SEL_WIDTH'($urandom_range(7));
      data = $urandom;
      if (roll < 50) begin
         func = pmt_pkg::FUNC_TICK;
      end else if (roll < 62) begin
         func = pmt_pkg::FUNC_READ;
      end else if (roll < 64) begin
         func = FUNC_UNUSED;
      end else begin
         func = pmt_pkg::FUNC_WRITE;
         case (sel)
            pmt_pkg::REG_CONTROL:
               if (pick < 75) data = 32'd1;
               else if (pick < 88) data = $urandom_range(3);
            pmt_pkg::REG_MATCH_CONTROL:
               if (pick < 90) data = $urandom_range(3);
            pmt_pkg::REG_PRESCALE:
               if (pick < 80) data = $urandom_range(3);
               else if (pick < 92) data = $urandom_range(20);
            pmt_pkg::REG_MATCH_VALUE:
               if (pick < 85) data = $urandom_range(12);
            pmt_pkg::REG_FLAGS:
               if (pick < 80) data = 32'd1;
            pmt_pkg::REG_COUNTER:
               if (pick < 45) data = $urandom_range(12);
               else if (pick < 75) data = 32'hFFFF_FFFF - $urandom_range(3);
            pmt_pkg::REG_PRESCALE_COUNT:
               if (pick < 80) data = $urandom_range(5);
            default: ;
         endcase
      end
   endtask

   task automatic report_failure(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
   endtask

   // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_failure("unexpected word", 32'h0, rsp_tdata[31:0]);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tdata[31:0] !== oldest.read_data)
               report_failure("read_data", oldest.read_data, rsp_tdata[31:0]);
            if (rsp_tdata[32] !== oldest.irq)
               report_failure("irq", {31'd0, oldest.irq}, {31'd0, rsp_tdata[32]});
            words_checked++;
            if (oldest.irq) irq_words++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d words outstanding",
                  cycle_count, pending_results.size());
         $display("FAIL prescaled_match_timer_top");
         $finish;
      end
   end

   // Stimulus: reset, the directed table, then random words in four phases of sender idling and receiver stalls.
   initial begin
      logic [pmt_pkg::FUNC_WIDTH-1:0] func;
      logic [pmt_pkg::SEL_WIDTH-1:0]  sel;
      logic [31:0]                    data;
      timer_result_type               typed_res;

      enable_bit = 1'b0;
      hold_reset_bit = 1'b0;
      match_irq_bit = 1'b0;
      match_reset_bit = 1'b0;
      prescale_val = '0;
      match_val = '0;
      irq_pending = 1'b0;
      timer_cnt = '0;
      prescale_cnt = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         typed_res.read_data = DIRECTED[row].want_read;
         typed_res.irq = DIRECTED[row].want_irq;
         send_word(DIRECTED[row].func, DIRECTED[row].sel, DIRECTED[row].data,
                   DIRECTED[row].known, typed_res);
      end

      typed_res = '0;
      for (int phase = 0; phase < 4; phase++) begin
         tx_idle_pct = TX_IDLE_PCT[phase];
         rx_stall_pct = RX_STALL_PCT[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Hold the receiver off for a long stretch while words keep coming.
            if (phase == 0 && n == 120) hold_requests++;
            pick_random_word(func, sel, data);
            send_word(func, sel, data, 1'b0, typed_res);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (directed table and four idling phases, one long hold-off).",
               words_sent);
      $display("Checked %0d result words, %0d of them with the match flag raised.",
               words_checked, irq_words);
      if (mismatch_count == 0) begin
         $display("PASS prescaled_match_timer_top");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("FAIL prescaled_match_timer_top");
      end
      $finish;
   end

endmodule
